### rtl/core/b64_pkg.sv
// Shared types, character constants and alphabet functions of the Base64 stream codec.
// Has no dependencies; every other file of the codec but b64_stream_ifs uses it by scoped names.
package b64_pkg;

  // Configuration register indexes.
  localparam int unsigned RegDecodeMode = 0;
  localparam int unsigned RegCount      = 1;

  // Results one input item can cause at most.
  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] CharPad   = 8'h3D;  // '='
  localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash = 8'h2F;  // '/'
  localparam logic [7:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [7:0] CharUpZ   = 8'h5A;  // 'Z'
  localparam logic [7:0] CharLoA   = 8'h61;  // 'a'
  localparam logic [7:0] CharLoZ   = 8'h7A;  // 'z'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'

  typedef struct packed {
    logic [7:0] data_out;
    logic       has_data;
    logic       last_out;
  } res_t;

  typedef struct packed {
    logic [2:0]       count;
    res_t [3:0]       res;
  } group_t;

  typedef struct packed {
    logic decode_mode;
    logic clear;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  // Maps a 6-bit group to its character of the standard alphabet.
  function automatic logic [7:0] enc_char(logic [5:0] v);
    logic [7:0] r;
    priority if (v < 6'd26) begin
      r = CharUpA + {2'b00, v};
    end else if (v < 6'd52) begin
      r = CharLoA + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = CharZero + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = CharPlus;
    end else begin
      r = CharSlash;
    end
    return r;
  endfunction

  // Maps a character back to its 6-bit value; valid is low outside the alphabet.
  function automatic sextet_t dec_char(logic [7:0] c);
    sextet_t r;
    r = '0;
    priority if (c >= CharUpA && c <= CharUpZ) begin
      r.valid = 1'b1;
      r.value = 6'(c - CharUpA);
    end else if (c >= CharLoA && c <= CharLoZ) begin
      r.valid = 1'b1;
      r.value = 6'(c - CharLoA + 8'd26);
    end else if (c >= CharZero && c <= CharNine) begin
      r.valid = 1'b1;
      r.value = 6'(c - CharZero + 8'd52);
    end else if (c == CharPlus) begin
      r.valid = 1'b1;
      r.value = 6'd62;
    end else if (c == CharSlash) begin
      r.valid = 1'b1;
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/core/b64_stream_ifs.sv
// Valid/ready stream interfaces of the Base64 codec: byte input and result output.
// Stand-alone; a transfer happens at a rising edge with valid and ready both high.
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       end_of_message;

  modport source (output valid, data_in, end_of_message, input ready);
  modport sink (input valid, data_in, end_of_message, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       has_data;
  logic       last_out;

  modport source (output valid, data_out, has_data, last_out, input ready);
  modport sink (input valid, data_out, has_data, last_out, output ready);
endinterface

### rtl/core/b64_cfg_regs.sv
// APB-style configuration register of the Base64 codec (decode_mode).
// Depends on b64_pkg; a write also asks the core to clear its message state.
module b64_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output b64_pkg::cfg_t cfg_o
);

  logic decode_mode_q, decode_mode_d;
  logic hit_mode;
  logic wr_mode;

  assign pready   = 1'b1;
  assign hit_mode = (paddr[2] == 1'(b64_pkg::RegDecodeMode));
  assign wr_mode  = psel && penable && pwrite && pready && hit_mode;

  assign decode_mode_d = wr_mode ? pwdata[0] : decode_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_mode_q <= 1'b0;
    end else begin
      decode_mode_q <= decode_mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (psel && hit_mode) begin
      prdata = {31'b0, decode_mode_q};
    end
  end

  assign cfg_o.decode_mode = decode_mode_q;
  assign cfg_o.clear       = wr_mode;

endmodule

### rtl/core/b64_core.sv
// Input register, message state and per-item result logic of the Base64 codec.
// Depends on b64_pkg and b64_in_if; hands a group of up to four results onward.
module b64_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64_pkg::cfg_t     cfg_i,
  b64_in_if.sink            in_if,
  input  logic              load_ready_i,
  output logic              load_valid_o,
  output b64_pkg::group_t   group_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       eom_q;

  // Message state: position within a 3-byte (encode) or 4-character (decode) group,
  // the previous byte or sextet, and whether padding has been met.
  logic [1:0] phase_q, phase_d;
  logic [7:0] prev_q, prev_d;
  logic       pad_q, pad_d;

  logic       advance;
  logic [7:0] chars [4];
  logic [2:0] n;
  b64_pkg::sextet_t sx;

  assign advance      = valid_q && load_ready_i;
  assign in_if.ready  = !valid_q || load_ready_i;
  assign load_valid_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_if.ready) begin
      valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      data_q <= in_if.data_in;
      eom_q  <= in_if.end_of_message;
    end
  end

  always_comb begin
    phase_d = phase_q;
    prev_d  = prev_q;
    pad_d   = pad_q;
    n       = 3'd0;
    sx      = b64_pkg::dec_char(data_q);
    for (int i = 0; i < 4; i++) begin
      chars[i] = b64_pkg::CharPad;
    end

    if (!cfg_i.decode_mode) begin
      prev_d = data_q;
      unique case (phase_q)
        2'd0: begin
          chars[0] = b64_pkg::enc_char(data_q[7:2]);
          chars[1] = b64_pkg::enc_char({data_q[1:0], 4'b0000});
          n        = eom_q ? 3'd4 : 3'd1;
          phase_d  = 2'd1;
        end
        2'd1: begin
          chars[0] = b64_pkg::enc_char({prev_q[1:0], data_q[7:4]});
          chars[1] = b64_pkg::enc_char({data_q[3:0], 2'b00});
          n        = eom_q ? 3'd3 : 3'd1;
          phase_d  = 2'd2;
        end
        default: begin
          chars[0] = b64_pkg::enc_char({prev_q[3:0], data_q[7:6]});
          chars[1] = b64_pkg::enc_char(data_q[5:0]);
          n        = 3'd2;
          phase_d  = 2'd0;
        end
      endcase
    end else if (!pad_q) begin
      if (data_q == b64_pkg::CharPad) begin
        pad_d = 1'b1;
      end else if (sx.valid) begin
        prev_d  = {2'b00, sx.value};
        phase_d = phase_q + 2'd1;
        unique case (phase_q)
          2'd0: n = 3'd0;
          2'd1: begin
            chars[0] = {prev_q[5:0], sx.value[5:4]};
            n        = 3'd1;
          end
          2'd2: begin
            chars[0] = {prev_q[3:0], sx.value[5:2]};
            n        = 3'd1;
          end
          default: begin
            chars[0] = {prev_q[1:0], sx.value};
            n        = 3'd1;
          end
        endcase
      end
    end

    for (int i = 0; i < 4; i++) begin
      group_o.res[i].data_out = chars[i];
      group_o.res[i].has_data = 1'b1;
      group_o.res[i].last_out = eom_q && (3'(i) + 3'd1 == n);
    end
    group_o.count = n;

    if (eom_q) begin
      // An end item that causes no data still closes the message with a marker.
      if (n == 3'd0) begin
        group_o.res[0].data_out = '0;
        group_o.res[0].has_data = 1'b0;
        group_o.res[0].last_out = 1'b1;
        group_o.count           = 3'd1;
      end
      phase_d = 2'd0;
      pad_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      pad_q   <= 1'b0;
    end else if (cfg_i.clear) begin
      phase_q <= 2'd0;
      pad_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      pad_q   <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prev_q <= prev_d;
    end
  end

endmodule

### rtl/core/b64_out_buf.sv
// Result buffer of the Base64 codec: holds one group, sends one result per cycle while ready.
// Depends on b64_pkg and b64_out_if.
module b64_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_valid_i,
  input  b64_pkg::group_t group_i,
  output logic            load_ready_o,
  b64_out_if.source       out_if
);

  b64_pkg::res_t slots_q [4];
  logic [2:0]    cnt_q;
  logic          pop;

  assign out_if.valid    = (cnt_q != 3'd0);
  assign out_if.data_out = slots_q[0].data_out;
  assign out_if.has_data = slots_q[0].has_data;
  assign out_if.last_out = slots_q[0].last_out;

  assign pop          = out_if.valid && out_if.ready;
  // A new group may come in as the final result of the current one leaves.
  assign load_ready_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (load_valid_i) begin
      cnt_q <= group_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i) begin
      for (int i = 0; i < 4; i++) begin
        slots_q[i] <= group_i.res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < 3; i++) begin
        slots_q[i] <= slots_q[i+1];
      end
    end
  end

endmodule

### rtl/core/base64_stream_codec.sv
// Top level of the streaming Base64 codec (standard alphabet, encode and decode).
// Depends on b64_pkg, b64_stream_ifs, b64_cfg_regs, b64_core and b64_out_buf.
//
//   port       role     transfer moves
//   ---------  -------  ---------------------------------------------
//   in_if      sink     one byte or character, end_of_message flag
//   out_if     source   one character or byte, has_data, last_out
//   APB        slave    decode_mode register at byte address 0
//
// An item is held in the input register; its results, up to four, then leave the output
// buffer one per cycle while out_if is ready, so the output buffer sets the rate. An item
// has zero to two results mid-message and up to four at a message end; a new group loads
// as the last result leaves. A stalled output holds the buffer and, once it is full, the input.
// Reset clears the handshake state, the group position, the padding flag and decode_mode; no clearing pass.
module base64_stream_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  b64_in_if.sink      in_if,
  b64_out_if.source   out_if
);

  b64_pkg::cfg_t   cfg;
  b64_pkg::group_t group;
  logic            load_valid;
  logic            load_ready;

  b64_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  b64_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_if        (in_if),
    .load_ready_i (load_ready),
    .load_valid_o (load_valid),
    .group_o      (group)
  );

  b64_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (load_valid),
    .group_i      (group),
    .load_ready_o (load_ready),
    .out_if       (out_if)
  );

endmodule
